[src/fractal_value_noise_2d_macros.svh]
// Assertion macros shared by the noise block.
`ifndef FRACTAL_VALUE_NOISE_2D_MACROS_SVH
`define FRACTAL_VALUE_NOISE_2D_MACROS_SVH
`ifndef SYNTH
`define FVN_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("implication check failed");
`define FVN_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("next-cycle check failed");
`else
`define FVN_ASSERT_IMPL(label, clk, rst, a, c)
`define FVN_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

[src/fvn_pkg.sv]
`default_nettype none
package fvn_pkg;
   localparam int DefOctaves      = 4;
   localparam int DefFractionBits = 16;
   localparam int OctStages       = 8;
   localparam int Latency         = OctStages + 3;
   localparam int CsrAddrWidth    = 3;
   localparam logic [0:0] RegSeed = 1'b0;
   localparam logic signed [28:0] FreqQ = 29'sd150323855;
   localparam logic [31:0] HmulX   = 32'd374761393;
   localparam logic [31:0] HmulY   = 32'd668265263;
   localparam logic [31:0] HmulS   = 32'd2246822519;
   localparam logic [31:0] HmulMix = 32'd1274126177;
endpackage
`default_nettype wire

[src/fvn_octave.sv]
`default_nettype none
module fvn_octave #(
   parameter int OCT           = 0,
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic [31:0]        seed,
   input  logic signed [31:0] coord_x,
   input  logic signed [31:0] coord_y,
   output logic signed [15:0] value
);
   import fvn_pkg::*;

   localparam int Sh = 32 - OCT;

   logic [31:0] seed_hs_ff;
   always_ff @(posedge clock) begin
      seed_hs_ff <= 32'((seed + 32'(OCT)) * HmulS);
   end

   // Stage 1: frequency scaling.
   logic signed [60:0] prod_x_ff, prod_y_ff;
   always_ff @(posedge clock) begin
      prod_x_ff <= coord_x * FreqQ;
      prod_y_ff <= coord_y * FreqQ;
   end

   logic signed [95:0] ext_x, ext_y;
   logic [31:0] cell_x, cell_y;
   logic [FRACTION_BITS-1:0] frac_x, frac_y;
   logic [15:0] fq_x, fq_y;
   assign ext_x  = 96'(prod_x_ff);
   assign ext_y  = 96'(prod_y_ff);
   assign cell_x = ext_x[Sh+FRACTION_BITS +: 32];
   assign cell_y = ext_y[Sh+FRACTION_BITS +: 32];
   assign frac_x = ext_x[Sh +: FRACTION_BITS];
   assign frac_y = ext_y[Sh +: FRACTION_BITS];

   generate
      if (FRACTION_BITS >= 16) begin : g_trunc
         assign fq_x = frac_x[FRACTION_BITS-1 -: 16];
         assign fq_y = frac_y[FRACTION_BITS-1 -: 16];
      end else begin : g_fill
         assign fq_x = {frac_x, {(16-FRACTION_BITS){1'b0}}};
         assign fq_y = {frac_y, {(16-FRACTION_BITS){1'b0}}};
      end
   endgenerate

   // Stage 2: fraction squared and cell products of the hash.
   logic [15:0] f_x_ff, f_y_ff, f2_x_ff, f2_y_ff;
   logic [31:0] p_x_ff, p_y_ff;
   logic [31:0] sq_x, sq_y;
   assign sq_x = 32'(fq_x) * 32'(fq_x);
   assign sq_y = 32'(fq_y) * 32'(fq_y);
   always_ff @(posedge clock) begin
      f_x_ff  <= fq_x;
      f_y_ff  <= fq_y;
      f2_x_ff <= sq_x[31:16];
      f2_y_ff <= sq_y[31:16];
      p_x_ff  <= 32'(cell_x * HmulX);
      p_y_ff  <= 32'(cell_y * HmulY);
   end

   // Stage 3: smoothstep weights and first hash mix of the four corners.
   logic [33:0] sm_x, sm_y;
   assign sm_x = 34'(f2_x_ff) * (34'(18'd196608) - 34'({f_x_ff, 1'b0}));
   assign sm_y = 34'(f2_y_ff) * (34'(18'd196608) - 34'({f_y_ff, 1'b0}));

   logic [15:0] w_x3_ff, w_y3_ff;
   logic [31:0] t_ff [4];
   logic [31:0] h_in [4];
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         h_in[c] = p_x_ff + ((c % 2) != 0 ? HmulX : 32'd0)
                 + p_y_ff + ((c / 2) != 0 ? HmulY : 32'd0) + seed_hs_ff;
      end
   end
   always_ff @(posedge clock) begin
      w_x3_ff <= sm_x[31:16];
      w_y3_ff <= sm_y[31:16];
      for (int c = 0; c < 4; c++) begin
         t_ff[c] <= h_in[c] ^ (h_in[c] >> 13);
      end
   end

   // Stage 4: final hash multiply.
   logic [15:0] w_x4_ff, w_y4_ff;
   logic [31:0] m_ff [4];
   always_ff @(posedge clock) begin
      w_x4_ff <= w_x3_ff;
      w_y4_ff <= w_y3_ff;
      for (int c = 0; c < 4; c++) begin
         m_ff[c] <= 32'(t_ff[c] * HmulMix);
      end
   end

   // Stage 5: corner values and horizontal interpolation products.
   logic [31:0] h2 [4];
   logic signed [15:0] cv [4];
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         h2[c] = m_ff[c] ^ (m_ff[c] >> 16);
         cv[c] = $signed({~h2[c][15], h2[c][14:0]});
      end
   end

   logic signed [16:0] d_top, d_bot, wx_s;
   assign d_top = 17'(cv[1]) - 17'(cv[0]);
   assign d_bot = 17'(cv[3]) - 17'(cv[2]);
   assign wx_s  = $signed({1'b0, w_x4_ff});

   logic [15:0] w_y5_ff;
   logic signed [15:0] a_top_ff, a_bot_ff;
   logic signed [33:0] p_top_ff, p_bot_ff;
   always_ff @(posedge clock) begin
      w_y5_ff  <= w_y4_ff;
      a_top_ff <= cv[0];
      a_bot_ff <= cv[2];
      p_top_ff <= d_top * wx_s;
      p_bot_ff <= d_bot * wx_s;
   end

   // Stage 6: horizontal results.
   logic [15:0] w_y6_ff;
   logic signed [15:0] top_ff, bot_ff;
   always_ff @(posedge clock) begin
      w_y6_ff <= w_y5_ff;
      top_ff  <= a_top_ff + 16'(p_top_ff >>> 16);
      bot_ff  <= a_bot_ff + 16'(p_bot_ff >>> 16);
   end

   // Stage 7: vertical interpolation product.
   logic signed [16:0] d_v, wy_s;
   assign d_v  = 17'(bot_ff) - 17'(top_ff);
   assign wy_s = $signed({1'b0, w_y6_ff});

   logic signed [15:0] top7_ff;
   logic signed [33:0] p_v_ff;
   always_ff @(posedge clock) begin
      top7_ff <= top_ff;
      p_v_ff  <= d_v * wy_s;
   end

   // Stage 8: octave value.
   logic signed [15:0] value_ff;
   always_ff @(posedge clock) begin
      value_ff <= top7_ff + 16'(p_v_ff >>> 16);
   end
   assign value = value_ff;
endmodule
`default_nettype wire

[src/fractal_value_noise_2d.sv]
// Throughput: one coordinate per cycle; busy is never raised because every stage moves on
// each clock and the receiver cannot stall the result strobe.
// Reset: synchronous, active high; clears the valid chain and sets the seed register to zero.
// Data registers are not reset; items in flight at reset are dropped.
`default_nettype none
`include "fractal_value_noise_2d_macros.svh"
module fractal_value_noise_2d #(
   parameter int OCTAVES       = fvn_pkg::DefOctaves,
   parameter int FRACTION_BITS = fvn_pkg::DefFractionBits
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [31:0]                   req_coord_x,
   input  logic signed [31:0]                   req_coord_y,
   output logic                                 rsp_valid,
   output logic signed [15:0]                   rsp_noise_value,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [fvn_pkg::CsrAddrWidth-1:0]     paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import fvn_pkg::*;

   // The weighted octave sum is divided by Div = 2^OCTAVES - 1. After adding a bias that
   // makes it non-negative, the quotient is estimated by a reciprocal multiply, which is
   // exact or one too small, and a single remainder compare fixes it.
   localparam int Div = (1 << OCTAVES) - 1;
   localparam int AccWidth = 16 + OCTAVES;
   localparam int RecWidth = 18;
   localparam logic [RecWidth-1:0] Recip = RecWidth'((1 << AccWidth) / Div);
   localparam logic [AccWidth-1:0] Bias  = AccWidth'(32768 * Div);

   // Configuration: the seed register, written in the access phase of an APB transfer.
   logic [31:0] seed_ff, seed_in;
   logic        csr_write;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      seed_in = seed_ff;
      if (csr_write && paddr[2] == RegSeed) begin
         seed_in = pwdata;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'd0;
      end else begin
         seed_ff <= seed_in;
      end
   end
   assign prdata = (paddr[2] == RegSeed) ? seed_ff : 32'd0;

   // Every stage advances each cycle, so a new transfer can be taken at every edge.
   assign busy = 1'b0;

   logic [Latency-1:0] valid_ff, valid_in;
   assign valid_in = {valid_ff[Latency-2:0], start && !busy};
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // One octave pipeline per octave, each hashing with seed plus its octave index.
   logic signed [15:0] oct_val [OCTAVES];
   generate
      for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
         fvn_octave #(
            .OCT           (o),
            .FRACTION_BITS (FRACTION_BITS)
         ) u_octave (
            .clock   (clock),
            .seed    (seed_ff),
            .coord_x (req_coord_x),
            .coord_y (req_coord_y),
            .value   (oct_val[o])
         );
      end
   endgenerate

   // Stage 9: weighted sum, biased to be non-negative.
   logic signed [AccWidth-1:0] acc;
   always_comb begin
      acc = '0;
      for (int o = 0; o < OCTAVES; o++) begin
         acc = acc + (AccWidth'(oct_val[o]) <<< (OCTAVES - 1 - o));
      end
   end

   logic [AccWidth-1:0] biased_ff;
   always_ff @(posedge clock) begin
      biased_ff <= AccWidth'(acc) + Bias;
   end

   // Stage 10: reciprocal multiply.
   logic [AccWidth+RecWidth-1:0] qprod_ff;
   logic [AccWidth-1:0]          biased10_ff;
   always_ff @(posedge clock) begin
      qprod_ff    <= (AccWidth+RecWidth)'(biased_ff) * (AccWidth+RecWidth)'(Recip);
      biased10_ff <= biased_ff;
   end

   // Stage 11: remainder correction and removal of the bias.
   logic [15:0]       q_est, q_fix;
   logic [AccWidth:0] q_times, rem;
   assign q_est   = qprod_ff[AccWidth +: 16];
   assign q_times = ((AccWidth+1)'(q_est) << OCTAVES) - (AccWidth+1)'(q_est);
   assign rem     = (AccWidth+1)'(biased10_ff) - q_times;
   assign q_fix   = q_est + ((rem >= (AccWidth+1)'(Div)) ? 16'd1 : 16'd0);

   logic signed [15:0] noise_ff;
   always_ff @(posedge clock) begin
      noise_ff <= $signed({~q_fix[15], q_fix[14:0]});
   end

   assign rsp_valid       = valid_ff[Latency-1];
   assign rsp_noise_value = noise_ff;

   // A result only ever follows an accepted transfer by exactly the pipeline latency.
   `FVN_ASSERT_IMPL(a_rsp_follows_req, clock, reset, rsp_valid, $past(start && !busy, Latency))
   // A write to the seed address lands in the seed register on the next edge.
   `FVN_ASSERT_NEXT(a_seed_write, clock, reset, csr_write && paddr[2] == RegSeed, seed_ff == $past(pwdata))
endmodule
`default_nettype wire

[test/fractal_value_noise_2d_test.sv]
`timescale 1ns / 1ps
module fractal_value_noise_2d_test;
   import fvn_pkg::*;

   localparam int NumOctaves   = 4;
   localparam int FracBits     = 16;
   localparam longint FreqStep = 150323855;
   localparam int RandomCount  = 1700;

   // Byte address of the seed register; it is the only register.
   localparam logic [CsrAddrWidth-1:0] SeedAddr = CsrAddrWidth'(4 * RegSeed);
   // An address that decodes to no register, so a write there must be ignored.
   localparam logic [CsrAddrWidth-1:0] UnusedAddr = CsrAddrWidth'(4);

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } coord_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_noise_value;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   fractal_value_noise_2d uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .rsp_valid(rsp_valid), .rsp_noise_value(rsp_noise_value),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   // The predictor keeps its own copy of the seed register.
   logic [31:0] model_seed = '0;

   coord_type pending_coords[$];
   logic signed [15:0] expected_noise[$];
   int gap_left = 0;
   int transfers_sent = 0;
   int transfers_checked = 0;
   int error_count = 0;
   bit sender_hold = 1'b0;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic [31:0] hash_corner(logic [31:0] cx, logic [31:0] cy,
                                               logic [31:0] s);
      logic [31:0] h;
      h = cx * HmulX + cy * HmulY + s * HmulS;
      h = (h ^ (h >> 13)) * HmulMix;
      return h ^ (h >> 16);
   endfunction

   function automatic longint corner_value(longint cx, longint cy, logic [31:0] s);
      logic [31:0] h;
      h = hash_corner(cx[31:0], cy[31:0], s);
      return longint'({16'd0, h[15:0]}) - 32768;
   endfunction

   // Smoothstepped Q0.16 weight from the low fraction bits.
   function automatic longint fade_weight(longint scaled);
      longint f;
      longint f2;
      f = scaled & ((64'sd1 << FracBits) - 1);
      f = (FracBits >= 16) ? (f >> (FracBits - 16)) : (f << (16 - FracBits));
      f2 = (f * f) >> 16;
      return (f2 * (3 * 65536 - 2 * f)) >> 16;
   endfunction

   function automatic longint blend(longint a, longint b, longint t);
      return a + floor_shr((b - a) * t, 16);
   endfunction

   function automatic logic signed [15:0] predict_noise(coord_type c, logic [31:0] seed);
      longint acc;
      longint sx, sy, cx, cy, wx, wy, top, bot, v, r;
      logic [31:0] s;
      acc = 0;
      for (int o = 0; o < NumOctaves; o++) begin
         s = seed + 32'(o);
         sx = floor_shr(longint'(c.x) * FreqStep, 32 - o);
         sy = floor_shr(longint'(c.y) * FreqStep, 32 - o);
         cx = floor_shr(sx, FracBits);
         cy = floor_shr(sy, FracBits);
         wx = fade_weight(sx);
         wy = fade_weight(sy);
         top = blend(corner_value(cx, cy, s), corner_value(cx + 1, cy, s), wx);
         bot = blend(corner_value(cx, cy + 1, s), corner_value(cx + 1, cy + 1, s), wx);
         v = blend(top, bot, wy);
         acc += v * (64'sd1 << (NumOctaves - 1 - o));
      end
      // Floor division by the weight total; the shift-free form keeps rounding downward.
      if (acc >= 0) r = acc / ((1 << NumOctaves) - 1);
      else r = -((-(acc + 1)) / ((1 << NumOctaves) - 1)) - 1;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   // Random gap: usually none or short, sometimes long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Driver: changes inputs on the falling edge. A transfer happens at the
   // rising edge where start is high and busy is low, so the expectation is
   // queued only once that edge has passed.
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_noise.push_back(predict_noise({req_coord_x, req_coord_y}, model_seed));
            transfers_sent++;
            void'(pending_coords.pop_front());
         end
         if (start && busy) begin
            // Hold the current item until the block takes it.
         end else if (sender_hold || pending_coords.size() == 0) begin
            start <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else begin
            start <= 1'b1;
            req_coord_x <= pending_coords[0].x;
            req_coord_y <= pending_coords[0].y;
            gap_left <= pick_gap();
         end
      end
   end

   // Monitor: the strobe lasts one cycle and cannot be held off.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_noise.size() == 0) begin
            $error("noise_value: result with no expectation, actual %0d", rsp_noise_value);
            error_count++;
         end else begin
            logic signed [15:0] want;
            want = expected_noise.pop_front();
            transfers_checked++;
            if (rsp_noise_value !== want) begin
               $error("noise_value: expected %0d, actual %0d", want, rsp_noise_value);
               error_count++;
            end
         end
      end
   end

   task automatic csr_write(logic [CsrAddrWidth-1:0] addr, logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == SeedAddr) model_seed = data;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Waits until every queued item has been sent and every result checked,
   // then lets the pipeline drain fully before the next register write.
   task automatic wait_drained();
      while (pending_coords.size() != 0 || start || expected_noise.size() != 0)
         @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] random_word();
      // Biases toward small magnitudes and the extremes so every bit toggles.
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 400)) - 200) << 16
                   | $urandom_range(0, 65535);
         2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
         default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000
                         : 32'h7fff_ffff - $urandom_range(0, 65535);
      endcase
   endfunction

   task automatic queue_coord(logic [31:0] x, logic [31:0] y);
      coord_type c;
      c.x = x;
      c.y = y;
      pending_coords.push_back(c);
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) queue_coord(random_word(), random_word());
   endtask

   initial begin
      logic [31:0] edge_vals[8];
      int hold_mark;
      edge_vals = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                    32'h0000_ffff, 32'h0001_0000, 32'hffff_0000, 32'h5555_aaaa};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with the reset seed: extremes of both coordinates,
      // including the cell wrap at the most negative and positive values.
      for (int i = 0; i < 8; i++) queue_coord(edge_vals[i], edge_vals[(i * 3) % 8]);
      for (int i = 0; i < 8; i++) queue_coord(edge_vals[i], edge_vals[i]);
      wait_drained();

      // A write to an address with no register must leave the seed alone.
      csr_write(UnusedAddr, 32'hdead_beef);
      queue_coord(32'h0123_4567, 32'hfedc_ba98);
      queue_coord(32'h8000_0000, 32'h7fff_ffff);
      wait_drained();

      // Seed extremes, where the per-octave seed wraps past 2^32.
      csr_write(SeedAddr, 32'hffff_ffff);
      for (int i = 0; i < 4; i++) queue_coord(edge_vals[i], edge_vals[7 - i]);
      run_random(RandomCount / 4);
      wait_drained();

      csr_write(SeedAddr, 32'hffff_fffe);
      run_random(RandomCount / 4);
      // Once part of this batch is in flight, the sender pauses until every
      // expected result has come, then resumes with the rest.
      hold_mark = transfers_sent + 100;
      while (transfers_sent < hold_mark) @(posedge clock);
      sender_hold = 1'b1;
      while (start || expected_noise.size() != 0) @(posedge clock);
      sender_hold = 1'b0;
      wait_drained();

      csr_write(SeedAddr, $urandom());
      run_random(RandomCount / 4);
      wait_drained();

      csr_write(SeedAddr, 32'h0);
      run_random(RandomCount / 4);
      wait_drained();

      $display("Sent %0d coordinates, extremes and random ones, under several seeds;",
               transfers_sent);
      $display("checked %0d results, with one full pause of the sender.", transfers_checked);
      if (error_count == 0 && expected_noise.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
